FILE: src/lfu_pkg.sv
// lfu_pkg: shared constants and types for the lfu cache
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;
  localparam logic [4:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } rsp_t;

  // search token passed along the cell chain
  typedef struct packed {
    logic              match;
    logic [IdxW-1:0]   match_idx;
    logic [31:0]       match_val;
    logic              vic_ok;
    logic [IdxW-1:0]   vic_idx;
    logic [31:0]       vic_key;
    logic [31:0]       vic_cnt;
    logic [63:0]       vic_stamp;
    logic              free_ok;
    logic [IdxW-1:0]   free_idx;
  } tok_t;

  // write command broadcast to the cells
  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] idx;
    logic            fresh;
    logic            upd_val;
    logic            inval;
    logic [31:0]     key;
    logic [31:0]     value;
    logic [63:0]     stamp;
  } wcmd_t;
endpackage
`default_nettype wire

FILE: src/lfu_if.sv
// lfu_if: valid/ready channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface lfu_req_if;
  logic valid;
  logic ready;
  lfu_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfu_rsp_if;
  logic valid;
  logic ready;
  lfu_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfu_cfg_if;
  logic valid;
  logic ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/lfu_cache_lru_tiebreak.sv
// lfu_cache_lru_tiebreak: lfu cache top level with cell chain and control
// an accepted item passes through the scan, done and output states in order;
// a new item is taken only in idle, after the result has been accepted;
// the token walks one cell per cycle along the chain of entry cells
// reset: synchronous active low; entries invalid, occupancy and stamp zero, capacity 16
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_lru_tiebreak (
  input  wire logic clk,
  input  wire logic rst_n,
  lfu_req_if.sink   in_ch,
  lfu_rsp_if.source out_ch,
  lfu_cfg_if.sink   cfg_ch
);
  import lfu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [CntW-1:0] step_r;
  req_t        req_r;
  rsp_t        rsp_r;
  rsp_t        rsp_nxt;
  logic [4:0]  cap_r;
  logic [CntW-1:0] occ_r;
  logic [63:0] stamp_r;
  logic        clr;
  tok_t        chain [Capacity+1];
  wcmd_t       wcmd;
  logic [CntW-1:0] cap_eff;
  tok_t        fin;

  // config write takes the idle slot ahead of a new item
  assign in_ch.ready = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = state_r == ST_IDLE;
  assign out_ch.valid = state_r == ST_OUT;
  assign out_ch.data = rsp_r;
  assign clr = in_ch.valid && in_ch.ready;
  assign fin = chain[Capacity];
  assign cap_eff = (cap_r > 5'(Capacity)) ? CntW'(Capacity) : CntW'(cap_r);

  assign chain[0] = '0;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    lfu_cell u_cell (
      .clk(clk), .rst_n(rst_n), .my_idx(IdxW'(g)), .srch_key(req_r.key),
      .clr(clr), .tok_in(chain[g]), .tok_out(chain[g+1]), .wcmd(wcmd)
    );
  end

  always_comb begin
    wcmd = '0;
    wcmd.key = req_r.key;
    wcmd.value = req_r.value;
    wcmd.stamp = stamp_r;
    if (state_r == ST_DONE) begin
      if (fin.match) begin
        if (req_r.req_type == REQ_GET || cap_eff != '0) begin
          wcmd.en = 1'b1;
          wcmd.idx = fin.match_idx;
          wcmd.upd_val = req_r.req_type == REQ_PUT;
        end
      end else if (req_r.req_type == REQ_PUT && cap_eff != '0) begin
        wcmd.en = 1'b1;
        wcmd.fresh = 1'b1;
        wcmd.idx = (occ_r >= cap_eff && fin.vic_ok) ? fin.vic_idx : fin.free_idx;
        if (!(occ_r >= cap_eff && fin.vic_ok) && !fin.free_ok) wcmd.en = 1'b0;
      end
    end
  end

  always_comb begin
    rsp_nxt = '0;
    if (fin.match) begin
      if (req_r.req_type == REQ_GET) begin
        rsp_nxt.hit = 1'b1;
        rsp_nxt.read_value = fin.match_val;
      end else if (cap_eff != '0) begin
        rsp_nxt.hit = 1'b1;
      end
    end else if (req_r.req_type == REQ_PUT && cap_eff != '0 &&
                 occ_r >= cap_eff && fin.vic_ok) begin
      rsp_nxt.evicted = 1'b1;
      rsp_nxt.evicted_key = fin.vic_key;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (clr) state_nxt = ST_SCAN;
      ST_SCAN: if (step_r == CntW'(Capacity)) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT:  if (out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      cap_r <= CAP_RESET;
      occ_r <= '0;
      stamp_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) cap_r <= cfg_ch.data;
      if (clr) begin
        req_r <= in_ch.data;
        step_r <= '0;
      end else if (state_r == ST_SCAN) begin
        step_r <= step_r + CntW'(1);
      end
      if (state_r == ST_DONE) begin
        rsp_r <= rsp_nxt;
        if (wcmd.en) stamp_r <= stamp_r + 64'd1;
        if (wcmd.en && wcmd.fresh && !rsp_nxt.evicted) occ_r <= occ_r + CntW'(1);
      end
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("accepting while result pending");
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CntW'(Capacity)) else $error("occupancy overflow");
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_DONE |=> $stable(stamp_r)) else $error("stamp moved outside update");
endmodule
`default_nettype wire

FILE: src/lfu_cell.sv
// lfu_cell: one cache entry with its registered search stage
`timescale 1ns / 1ps
`default_nettype none
module lfu_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [lfu_pkg::IdxW-1:0] my_idx,
  input  wire logic [31:0]           srch_key,
  input  wire logic                  clr,
  input  wire lfu_pkg::tok_t         tok_in,
  output lfu_pkg::tok_t              tok_out,
  input  wire lfu_pkg::wcmd_t        wcmd
);
  import lfu_pkg::*;
  logic        valid_r;
  logic [31:0] key_r, val_r, cnt_r;
  logic [63:0] stamp_r;
  tok_t        t_nxt, tok_r;
  logic        better;

  always_comb begin
    t_nxt = tok_in;
    better = !tok_in.vic_ok || cnt_r < tok_in.vic_cnt ||
             (cnt_r == tok_in.vic_cnt && stamp_r < tok_in.vic_stamp);
    if (valid_r && key_r == srch_key && !tok_in.match) begin
      t_nxt.match = 1'b1;
      t_nxt.match_idx = my_idx;
      t_nxt.match_val = val_r;
    end
    if (valid_r && better) begin
      t_nxt.vic_ok = 1'b1;
      t_nxt.vic_idx = my_idx;
      t_nxt.vic_key = key_r;
      t_nxt.vic_cnt = cnt_r;
      t_nxt.vic_stamp = stamp_r;
    end
    if (!valid_r && !tok_in.free_ok) begin
      t_nxt.free_ok = 1'b1;
      t_nxt.free_idx = my_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      tok_r <= '0;
    end else begin
      tok_r <= t_nxt;
    end
  end
  assign tok_out = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wcmd.en && wcmd.idx == my_idx) begin
      if (wcmd.inval) begin
        valid_r <= 1'b0;
      end else if (wcmd.fresh) begin
        valid_r <= 1'b1;
        key_r <= wcmd.key;
        val_r <= wcmd.value;
        cnt_r <= 32'd1;
        stamp_r <= wcmd.stamp;
      end else begin
        if (wcmd.upd_val) val_r <= wcmd.value;
        if (cnt_r != 32'hFFFF_FFFF) cnt_r <= cnt_r + 32'd1;
        stamp_r <= wcmd.stamp;
      end
    end
  end
endmodule
`default_nettype wire
